// ===== rtl/core/msa_pkg.sv =====
// Shared constants and the queue word type of the sliding average unit.
package msa_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ANT_W = 2;
  localparam int PAIR_W = 2;
  // Highest channel number that the port widths allow is 3 * PAIRS + 3, 15 at the defaults.
  localparam int CHAN_W = 6;

  localparam int WINDOW_DEF = 10;
  localparam int ANTENNAS_DEF = 4;
  localparam int PEAKS_DEF = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0] chan;
    logic oor;
  } item_t;

endpackage

// ===== rtl/core/msa_ram.sv =====
// Generic single write port RAM with registered read.
module msa_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/msa_front.sv =====
// Front end: accepts words, works out the channel and queues them two deep.
module msa_front #(
  parameter int ANTENNAS = msa_pkg::ANTENNAS_DEF,
  parameter int PEAKS_PER_ANTENNA = msa_pkg::PEAKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [msa_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [msa_pkg::ANT_W-1:0]           in_antenna,
  input  logic [msa_pkg::PAIR_W-1:0]          in_pair,
  input  logic                                take,
  output logic                                avail,
  output msa_pkg::item_t                      head
);

  localparam int PAIRS = PEAKS_PER_ANTENNA / 2;
  localparam int CHANNELS = ANTENNAS * PAIRS;

  msa_pkg::item_t slot_r [2];
  msa_pkg::item_t item;
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_push, do_pop;

  always_comb begin
    item.sample = in_sample;
    item.chan = msa_pkg::CHAN_W'(in_antenna) * msa_pkg::CHAN_W'(PAIRS)
              + msa_pkg::CHAN_W'(in_pair);
    item.oor = (32'(item.chan) >= CHANNELS);
  end

  assign full = cnt_r[1];
  assign avail = (cnt_r != 2'd0);
  assign head = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= item;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== rtl/core/msa_div.sv =====
// Bit-serial restoring divider, signed dividend by small positive divisor.
module msa_div #(
  parameter int NW = 28,
  parameter int DW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic neg_r, done_r;
  logic [DW:0] trial;
  logic fits;

  assign trial = {rem_r, q_r[NW-1]};
  assign fits = (trial >= {1'b0, den_r});
  assign done = done_r;
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num[NW-1] ? NW'(-num) : NW'(num);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NW-1];
    end else if (cnt_r != '0) begin
      q_r <= {q_r[NW-2:0], fits};
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
    end
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      // done stays up, with the quotient held, until the next start
      done_r <= start ? 1'b0 : ((cnt_r == CW'(1)) || done_r);
      if (start) cnt_r <= CW'(NW);
      else if (cnt_r != '0) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== rtl/core/msa_back.sv =====
// Back end: per-channel state and ring update, division and result register.
module msa_back #(
  parameter int WINDOW = msa_pkg::WINDOW_DEF,
  parameter int ANTENNAS = msa_pkg::ANTENNAS_DEF,
  parameter int PEAKS_PER_ANTENNA = msa_pkg::PEAKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 avail,
  input  msa_pkg::item_t                       head,
  output logic                                 take,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [msa_pkg::SAMPLE_W-1:0]  out_average
);

  localparam int SW = msa_pkg::SAMPLE_W;
  localparam int CHANNELS = ANTENNAS * (PEAKS_PER_ANTENNA / 2);
  localparam int SD = (CHANNELS < 2) ? 2 : CHANNELS;
  localparam int CW = $clog2(SD);
  localparam int RD = SD * WINDOW;
  localparam int RW = $clog2(RD);
  localparam int PW = $clog2(WINDOW);
  localparam int DW = $clog2(WINDOW + 1);
  localparam int SUMW = SW + $clog2(WINDOW);
  localparam int STW = SUMW + PW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDST = 2'd1;
  localparam logic [1:0] S_RDRING = 2'd2;
  localparam logic [1:0] S_DIV = 2'd3;

  logic [1:0] state_r;
  logic signed [SW-1:0] smp_r;
  logic [CW-1:0] addr_r;
  logic [PW-1:0] pos_r;
  logic full_r;
  logic signed [SUMW-1:0] sum_r;
  logic [RW-1:0] ring_addr_r;
  logic [SD-1:0] vld_r;
  logic out_full_r;
  logic signed [SW-1:0] out_avg_r;

  logic [STW-1:0] st_rdata, st_wdata;
  logic [SW-1:0] ring_rdata;
  logic [PW-1:0] pos_cur;
  logic [RW-1:0] ring_raddr;
  logic last, full_new, upd;
  logic [PW-1:0] pos_new;
  logic signed [SUMW-1:0] sum_new;
  logic [DW-1:0] den;
  logic div_done;
  logic signed [SUMW-1:0] quo;
  logic ld_ok;

  // result register can take a new word this cycle
  assign ld_ok = !out_full_r || pop;
  assign take = (state_r == S_IDLE) && avail && (!head.oor || ld_ok);
  assign empty = !out_full_r;
  assign out_average = out_avg_r;
  assign upd = (state_r == S_RDRING);

  // an untouched channel reads as the reset state
  assign pos_cur = vld_r[addr_r] ? st_rdata[PW:1] : '0;
  assign ring_raddr = RW'(RW'(addr_r) * RW'(WINDOW) + RW'(pos_cur));

  assign last = (pos_r == PW'(WINDOW - 1));
  assign pos_new = last ? '0 : pos_r + PW'(1);
  assign full_new = full_r || last;
  assign sum_new = sum_r + SUMW'(smp_r)
                 - (full_r ? SUMW'($signed(ring_rdata)) : SUMW'(0));
  assign den = full_new ? DW'(WINDOW) : DW'(pos_r) + DW'(1);
  assign st_wdata = {sum_new, pos_new, full_new};

  msa_ram #(.W(STW), .D(SD)) u_st_ram (
    .clk(clk), .we(upd), .waddr(addr_r), .wdata(st_wdata),
    .raddr(CW'(head.chan)), .rdata(st_rdata)
  );

  msa_ram #(.W(SW), .D(RD)) u_ring_ram (
    .clk(clk), .we(upd), .waddr(ring_addr_r), .wdata(smp_r),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  msa_div #(.NW(SUMW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(upd), .num(sum_new), .den(den),
    .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      smp_r <= head.sample;
      addr_r <= CW'(head.chan);
    end
    if (state_r == S_RDST) begin
      pos_r <= pos_cur;
      full_r <= vld_r[addr_r] && st_rdata[0];
      sum_r <= vld_r[addr_r] ? st_rdata[STW-1:PW+1] : '0;
      ring_addr_r <= ring_raddr;
    end
    if (take && head.oor) begin
      out_avg_r <= '0;
    end else if (state_r == S_DIV && div_done && ld_ok) begin
      out_avg_r <= quo[SW-1:0];
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      out_full_r <= 1'b0;
    end else begin
      if (upd) vld_r[addr_r] <= 1'b1;
      if (pop && out_full_r) out_full_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (head.oor) out_full_r <= 1'b1;
            else state_r <= S_RDST;
          end
        end
        S_RDST: state_r <= S_RDRING;
        S_RDRING: state_r <= S_DIV;
        S_DIV: begin
          // quotient is held while the result register is still occupied
          if (div_done && ld_ok) begin
            out_full_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/multichannel_sliding_average_unit.sv =====
// Multichannel sliding average unit: top level.
// Input side is a queue: present in_sample, in_antenna and in_pair with push;
// a word is taken on a clock edge with push high and full low. A two-deep
// queue holds words while the back end works.
// Result side is a queue too: while empty is low, out_average holds the
// truncated mean of the channel's last WINDOW samples (fewer while filling);
// pop with empty low takes it. Each input word gives one result, in order.
// After acceptance the back end reads the channel state, then its ring slot,
// then divides in the bit-serial divider, one quotient bit per cycle; words
// are worked one at a time, the next only once the last result is loaded.
// A channel number beyond the channel count gives a result of zero and no
// state change.
// A stalled receiver holds the result register; the back end finishes the
// next word and waits with it, then the input queue fills and full rises.
// Synchronous reset (rst_n low) clears both queues and marks every channel
// empty; no clearing pass, the unit takes words straight after reset.
module multichannel_sliding_average_unit #(
  parameter int WINDOW = msa_pkg::WINDOW_DEF,
  parameter int ANTENNAS = msa_pkg::ANTENNAS_DEF,
  parameter int PEAKS_PER_ANTENNA = msa_pkg::PEAKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [msa_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [msa_pkg::ANT_W-1:0]            in_antenna,
  input  logic [msa_pkg::PAIR_W-1:0]           in_pair,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [msa_pkg::SAMPLE_W-1:0]  out_average
);

  msa_pkg::item_t head;
  logic avail, take;

  msa_front #(.ANTENNAS(ANTENNAS), .PEAKS_PER_ANTENNA(PEAKS_PER_ANTENNA)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample(in_sample), .in_antenna(in_antenna), .in_pair(in_pair),
    .take(take), .avail(avail), .head(head)
  );

  msa_back #(
    .WINDOW(WINDOW), .ANTENNAS(ANTENNAS), .PEAKS_PER_ANTENNA(PEAKS_PER_ANTENNA)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .take(take),
    .empty(empty), .pop(pop), .out_average(out_average)
  );

endmodule

// ===== tb/msa_checker.sv =====
// Checker for the sliding average unit: predicts each average and compares.
`timescale 1ns / 1ps
module msa_checker #(
  parameter int WINDOW = msa_pkg::WINDOW_DEF,
  parameter int ANTENNAS = msa_pkg::ANTENNAS_DEF,
  parameter int PEAKS_PER_ANTENNA = msa_pkg::PEAKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic                                full,
  input  logic signed [msa_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [msa_pkg::ANT_W-1:0]           in_antenna,
  input  logic [msa_pkg::PAIR_W-1:0]          in_pair,
  input  logic                                empty,
  input  logic                                pop,
  input  logic signed [msa_pkg::SAMPLE_W-1:0] out_average,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  averages_seen
);
  localparam int PAIRS = PEAKS_PER_ANTENNA / 2;
  localparam int CHANS = ANTENNAS * PAIRS;

  logic signed [msa_pkg::SAMPLE_W-1:0] ring [CHANS][WINDOW];
  longint chan_sum [CHANS];
  int chan_pos [CHANS];
  bit chan_full [CHANS];
  logic signed [msa_pkg::SAMPLE_W-1:0] expected_averages [$];

  function automatic logic signed [msa_pkg::SAMPLE_W-1:0] next_average(
    logic signed [msa_pkg::SAMPLE_W-1:0] s, int ant, int pr);
    int ch;
    int p;
    longint mean;
    ch = ant * PAIRS + pr;
    if (ch >= CHANS) return '0;
    p = chan_pos[ch];
    chan_sum[ch] += s;
    if (chan_full[ch]) chan_sum[ch] -= ring[ch][p];
    ring[ch][p] = s;
    p++;
    if (p == WINDOW) begin
      p = 0;
      chan_full[ch] = 1;
    end
    chan_pos[ch] = p;
    // SV division of signed integers truncates toward zero
    mean = chan_full[ch] ? chan_sum[ch] / WINDOW : chan_sum[ch] / p;
    return mean[msa_pkg::SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_averages.delete();
      fail_count <= 0;
      averages_seen <= 0;
      pending <= 0;
      for (int c = 0; c < CHANS; c++) begin
        chan_sum[c] = 0;
        chan_pos[c] = 0;
        chan_full[c] = 0;
      end
    end else begin
      if (push && !full)
        expected_averages.push_back(next_average(in_sample, in_antenna, in_pair));
      if (pop && !empty) begin
        averages_seen <= averages_seen + 1;
        if (expected_averages.size() == 0) begin
          $error("average word with nothing expected: %0d", out_average);
          fail_count <= fail_count + 1;
        end else if (expected_averages[0] !== out_average) begin
          $error("average: expected %0d, got %0d", expected_averages[0], out_average);
          fail_count <= fail_count + 1;
          void'(expected_averages.pop_front());
        end else begin
          void'(expected_averages.pop_front());
        end
      end
      pending <= expected_averages.size();
    end
  end
endmodule

// ===== tb/tb_multichannel_sliding_average_unit.sv =====
// Testbench top for the sliding average unit: stimulus and verdict.
`timescale 1ns / 1ps
module tb_multichannel_sliding_average_unit;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  logic signed [msa_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic [msa_pkg::ANT_W-1:0] in_antenna = '0;
  logic [msa_pkg::PAIR_W-1:0] in_pair = '0;
  logic signed [msa_pkg::SAMPLE_W-1:0] out_average;
  int fail_count, pending, averages_seen;
  int words_sent;
  longint cycles;

  multichannel_sliding_average_unit dut (.*);
  msa_checker chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= (rst_n === 0) ? 0 : cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall before each pop, sometimes none at all
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic send_word(logic signed [23:0] s, logic [1:0] ant, logic [1:0] pr,
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    in_sample <= s;
    in_antenna <= ant;
    in_pair <= pr;
    push <= 1;
    do @(posedge clk); while (full);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 15)) - 24'sd8;
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    bit burst;
    words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: first sample, extremes filling past the window, every channel
    send_word(24'sh7fffff, 2'd0, 2'd0, 0);
    for (int i = 0; i < 12; i++) send_word(24'sh7fffff, 2'd0, 2'd0, 0);
    for (int i = 0; i < 12; i++) send_word(24'sh800000, 2'd3, 2'd3, 1);
    for (int c = 0; c < 16; c++) send_word(-24'sd7, c[3:2], c[1:0], 0);
    // random: mostly channel bursts so windows roll over, rest scattered
    while (words_sent < 2040) begin
      burst = $urandom_range(0, 3) != 0;
      if (burst) begin
        logic [1:0] a, p;
        a = 2'($urandom());
        p = 2'($urandom());
        repeat ($urandom_range(1, 25))
          send_word(rand_sample(), a, p, $urandom_range(0, 4) == 0);
      end else begin
        send_word(rand_sample(), 2'($urandom()), 2'($urandom()), 0);
      end
    end
    push <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d sample words across all 16 channels, checked %0d averages",
             words_sent, averages_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
